// ===== src/c2d_pkg.sv =====
// shared types, codes and helpers for the multichannel 2d convolution core
package c2d_pkg;

	localparam int S_TDATA_W  = 40;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 32;
	localparam int M_TUSER_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int ACC_W      = 41;

	localparam logic signed [ACC_W-1:0] SUM_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [ACC_W-1:0] SUM_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

	typedef enum logic [1:0] {
		CMD_PIX  = 2'd0,
		CMD_WGT  = 2'd1,
		CMD_CALC = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_SAT = 2'd1,
		STAT_OOR = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_CH  = 3'd0,
		REG_OUT_CH = 3'd1,
		REG_KSIZE  = 3'd2,
		REG_FH     = 3'd3,
		REG_FW     = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	function automatic logic [6:0] eff_clamp(input logic [6:0] v, input int unsigned maxv);
		logic [6:0] r;
		if (v == 7'd0) begin
			r = 7'd1;
		end else if (32'(v) > maxv) begin
			r = 7'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== src/c2d_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module c2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/conv2d_valid_multichannel_core.sv =====
// top level of the multichannel 2d convolution core (stride 1, valid borders, no bias)
// pixel and weight writes give no result
// a compute request issues one memory read pair per tap of nic input channels and a k by k kernel,
// then the read, multiply and accumulate stages drain before the result register loads; an out of
// range request skips the reads, and a stalled output holds the result back
// one request at a time; reset clears control, loads default configuration, stores stay undefined
module conv2d_valid_multichannel_core #(
	parameter int MAX_IN_CH  = 4,
	parameter int MAX_OUT_CH = 16,
	parameter int MAX_KERNEL = 7,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_WIDTH  = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [c2d_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [c2d_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// value, out_ch, in_ch, row, col, krow, kcol
	input  logic [c2d_pkg::S_TDATA_W-1:0]    s_tdata,
	// cmd
	input  logic [c2d_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// sum
	output logic [c2d_pkg::M_TDATA_W-1:0]    m_tdata,
	// status
	output logic [c2d_pkg::M_TUSER_W-1:0]    m_tuser
);
	import c2d_pkg::*;

	localparam int PIX_DEPTH = MAX_IN_CH * MAX_HEIGHT * MAX_WIDTH;
	localparam int WGT_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
	localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
	localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

	// configuration
	logic [2:0] in_ch_cfg_q;
	logic [4:0] out_ch_cfg_q;
	logic [2:0] ksize_q;
	logic [6:0] fh_q;
	logic [6:0] fw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_cfg_q  <= 3'd1;
			out_ch_cfg_q <= 5'd1;
			ksize_q      <= 3'd3;
			fh_q         <= 7'd64;
			fw_q         <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_IN_CH:  in_ch_cfg_q  <= cfg_wdata[2:0];
				REG_OUT_CH: out_ch_cfg_q <= cfg_wdata[4:0];
				REG_KSIZE:  ksize_q      <= cfg_wdata[2:0];
				REG_FH:     fh_q         <= cfg_wdata;
				REG_FW:     fw_q         <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [6:0] nic, noc, k, h, w;
	assign nic = eff_clamp(7'(in_ch_cfg_q), MAX_IN_CH);
	assign noc = eff_clamp(7'(out_ch_cfg_q), MAX_OUT_CH);
	assign k   = eff_clamp(7'(ksize_q), MAX_KERNEL);
	assign h   = eff_clamp(fh_q, MAX_HEIGHT);
	assign w   = eff_clamp(fw_q, MAX_WIDTH);

	// request fields
	logic [15:0] f_value;
	logic [3:0]  f_oc;
	logic [1:0]  f_ic;
	logic [5:0]  f_row, f_col;
	logic [2:0]  f_kr, f_kc;
	assign f_value = s_tdata[15:0];
	assign f_oc    = s_tdata[19:16];
	assign f_ic    = s_tdata[21:20];
	assign f_row   = s_tdata[27:22];
	assign f_col   = s_tdata[33:28];
	assign f_kr    = s_tdata[36:34];
	assign f_kc    = s_tdata[39:37];

	state_t state_q;
	logic   accept;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	logic pix_ok, wgt_ok, oor;
	assign pix_ok = (7'(f_ic) < nic) && (7'(f_row) < h) && (7'(f_col) < w);
	assign wgt_ok = (7'(f_oc) < noc) && (7'(f_ic) < nic) && (7'(f_kr) < k) && (7'(f_kc) < k);
	assign oor    = (7'(f_oc) >= noc) || (k > h) || (k > w)
		|| ((8'(f_row) + 8'(k)) > 8'(h)) || ((8'(f_col) + 8'(k)) > 8'(w));

	logic pix_we, wgt_we;
	always_comb begin
		pix_we = 1'b0;
		wgt_we = 1'b0;
		unique case (s_tuser)
			CMD_PIX:  pix_we = accept && pix_ok;
			CMD_WGT:  wgt_we = accept && wgt_ok;
			default: ;
		endcase
	end

	// compute context and tap counters
	logic [3:0] oc_q;
	logic [5:0] r_q, c_q;
	logic [2:0] ic_q, kr_q, kc_q;
	logic       oor_q;

	logic [6:0] ra, cb;
	assign ra = 7'(r_q) + 7'(kr_q);
	assign cb = 7'(c_q) + 7'(kc_q);

	logic [PIX_AW-1:0] pix_waddr, pix_raddr;
	logic [WGT_AW-1:0] wgt_waddr, wgt_raddr;
	assign pix_waddr = PIX_AW'((PIX_AW'(f_ic) * PIX_AW'(MAX_HEIGHT) + PIX_AW'(f_row))
		* PIX_AW'(MAX_WIDTH) + PIX_AW'(f_col));
	assign pix_raddr = PIX_AW'((PIX_AW'(ic_q) * PIX_AW'(MAX_HEIGHT) + PIX_AW'(ra))
		* PIX_AW'(MAX_WIDTH) + PIX_AW'(cb));
	assign wgt_waddr = WGT_AW'(((WGT_AW'(f_oc) * WGT_AW'(MAX_IN_CH) + WGT_AW'(f_ic))
		* WGT_AW'(MAX_KERNEL) + WGT_AW'(f_kr)) * WGT_AW'(MAX_KERNEL) + WGT_AW'(f_kc));
	assign wgt_raddr = WGT_AW'(((WGT_AW'(oc_q) * WGT_AW'(MAX_IN_CH) + WGT_AW'(ic_q))
		* WGT_AW'(MAX_KERNEL) + WGT_AW'(kr_q)) * WGT_AW'(MAX_KERNEL) + WGT_AW'(kc_q));

	logic [15:0] pix_rdata, wgt_rdata;

	c2d_ram #(.WIDTH(16), .DEPTH(PIX_DEPTH), .AW(PIX_AW)) u_pix_ram (
		.clk   (clk),
		.we    (pix_we),
		.waddr (pix_waddr),
		.wdata (f_value),
		.raddr (pix_raddr),
		.rdata (pix_rdata)
	);

	c2d_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH), .AW(WGT_AW)) u_wgt_ram (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (wgt_waddr),
		.wdata (f_value),
		.raddr (wgt_raddr),
		.rdata (wgt_rdata)
	);

	logic last_kc, last_kr, last_ic, last_tap, issue;
	assign last_kc  = (7'(kc_q) == k - 7'd1);
	assign last_kr  = (7'(kr_q) == k - 7'd1);
	assign last_ic  = (7'(ic_q) == nic - 7'd1);
	assign last_tap = last_kc && last_kr && last_ic;
	assign issue    = (state_q == S_RUN);

	logic                    issue_s1;
	logic                    v_s2;
	logic signed [31:0]      prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	logic                 out_free;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ic_q     <= '0;
			kr_q     <= '0;
			kc_q     <= '0;
			issue_s1 <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			issue_s1 <= issue;
			v_s2     <= issue_s1;
			unique case (state_q)
				S_IDLE: begin
					ic_q <= '0;
					kr_q <= '0;
					kc_q <= '0;
					if (accept && s_tuser == CMD_CALC) begin
						state_q <= oor ? S_DONE : S_RUN;
					end
				end
				S_RUN: begin
					if (last_kc) begin
						kc_q <= '0;
						if (last_kr) begin
							kr_q <= '0;
							ic_q <= ic_q + 3'd1;
						end else begin
							kr_q <= kr_q + 3'd1;
						end
					end else begin
						kc_q <= kc_q + 3'd1;
					end
					if (last_tap) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!issue_s1 && !v_s2) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request context and multiply-accumulate datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			oc_q  <= f_oc;
			r_q   <= f_row;
			c_q   <= f_col;
			oor_q <= oor;
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		prod_s2 <= $signed(pix_rdata) * $signed(wgt_rdata);
	end

	// saturation and result register
	logic [M_TDATA_W-1:0] sum_d;
	status_t              stat_d;
	always_comb begin
		priority if (oor_q) begin
			sum_d  = '0;
			stat_d = STAT_OOR;
		end else if (acc_q > SUM_MAX) begin
			sum_d  = M_TDATA_W'(SUM_MAX);
			stat_d = STAT_SAT;
		end else if (acc_q < SUM_MIN) begin
			sum_d  = M_TDATA_W'(SUM_MIN);
			stat_d = STAT_SAT;
		end else begin
			sum_d  = acc_q[M_TDATA_W-1:0];
			stat_d = STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= sum_d;
			m_tuser_q <= stat_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_issue_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		issue_s1 |-> (state_q == S_RUN || state_q == S_DRAIN))
		else $error("memory read in flight outside compute");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (m_tvalid && state_q == S_IDLE))
		else $error("result not presented after compute");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == STAT_OOR) |-> (m_tdata == '0))
		else $error("out of range result carries nonzero sum");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_we || wgt_we) |-> (!issue_s1 && !v_s2))
		else $error("store write while taps in flight");
endmodule

// ===== dv/tb_top.sv =====
// testbench for the multichannel 2d convolution core: directed and random requests
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import c2d_pkg::*;

	localparam int IN_CH_MAX    = 4;
	localparam int OUT_CH_MAX   = 16;
	localparam int KERN_MAX     = 7;
	localparam int ROWS_MAX     = 64;
	localparam int COLS_MAX     = 64;
	localparam int PIX_WORDS    = IN_CH_MAX * ROWS_MAX * COLS_MAX;
	localparam int WGT_WORDS    = OUT_CH_MAX * IN_CH_MAX * KERN_MAX * KERN_MAX;
	localparam int CALC_LATENCY = IN_CH_MAX * KERN_MAX * KERN_MAX + 4;
	localparam int SINK_HOLD    = 600;
	localparam int RANDOM_ITEMS = 60;

	localparam logic [1:0]  CMD_NONE = 2'd3;
	localparam logic [15:0] Q_MAX    = 16'h7FFF;
	localparam logic [15:0] Q_MIN    = 16'h8000;
	localparam logic [15:0] Q_ONE    = 16'h0100;
	localparam longint      ACC_HI   = 64'sd2147483647;
	localparam longint      ACC_LO   = -64'sd2147483648;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] value;
		logic [3:0]  oc;
		logic [1:0]  ic;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [2:0]  kr;
		logic [2:0]  kc;
	} conv_req_t;

	localparam int REQ_W = $bits(conv_req_t);

	typedef struct {
		logic [31:0] sum;
		status_t     status;
	} conv_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic [S_TUSER_W-1:0]  s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;

	logic [2:0] reg_in_ch  = 3'd1;
	logic [4:0] reg_out_ch = 5'd1;
	logic [2:0] reg_ksize  = 3'd3;
	logic [6:0] reg_fh     = 7'd64;
	logic [6:0] reg_fw     = 7'd64;

	logic signed [15:0] pix_mem [PIX_WORDS];
	logic signed [15:0] wgt_mem [WGT_WORDS];
	bit                 pix_known [PIX_WORDS];
	bit                 wgt_known [WGT_WORDS];

	conv_result_t pending_sums [$];
	int           mismatches   = 0;
	int           useful_items = 0;
	bit           quiet        = 1'b0;
	bit           sink_hold    = 1'b0;

	conv2d_valid_multichannel_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
		if (v == 0) begin
			return 1;
		end
		return (v > top) ? top : v;
	endfunction

	function automatic void cur_dims(output int unsigned nic, noc, k, h, w);
		nic = clamp_dim(reg_in_ch, IN_CH_MAX);
		noc = clamp_dim(reg_out_ch, OUT_CH_MAX);
		k   = clamp_dim(reg_ksize, KERN_MAX);
		h   = clamp_dim(reg_fh, ROWS_MAX);
		w   = clamp_dim(reg_fw, COLS_MAX);
	endfunction

	function automatic int unsigned pix_addr(int unsigned ic, int unsigned r, int unsigned c);
		return (ic * ROWS_MAX + r) * COLS_MAX + c;
	endfunction

	function automatic int unsigned wgt_addr(int unsigned oc, int unsigned ic,
			int unsigned kr, int unsigned kc);
		return ((oc * IN_CH_MAX + ic) * KERN_MAX + kr) * KERN_MAX + kc;
	endfunction

	function automatic bit in_window(int unsigned oc, int unsigned r, int unsigned c);
		int unsigned nic, noc, k, h, w;
		cur_dims(nic, noc, k, h, w);
		return oc < noc && k <= h && k <= w && r + k <= h && c + k <= w;
	endfunction

	function automatic conv_result_t conv_window_sum(conv_req_t req);
		int unsigned  nic, noc, k, h, w;
		longint       acc;
		conv_result_t res;
		cur_dims(nic, noc, k, h, w);
		res.sum    = '0;
		res.status = STAT_OK;
		if (!in_window(req.oc, req.row, req.col)) begin
			res.status = STAT_OOR;
			return res;
		end
		acc = 0;
		for (int i = 0; i < nic; i++) begin
			for (int a = 0; a < k; a++) begin
				for (int b = 0; b < k; b++) begin
					acc += longint'(pix_mem[pix_addr(i, req.row + a, req.col + b)])
						* longint'(wgt_mem[wgt_addr(req.oc, i, a, b)]);
				end
			end
		end
		if (acc > ACC_HI) begin
			acc        = ACC_HI;
			res.status = STAT_SAT;
		end else if (acc < ACC_LO) begin
			acc        = ACC_LO;
			res.status = STAT_SAT;
		end
		res.sum = acc[31:0];
		return res;
	endfunction

	function automatic void apply_item(conv_req_t req);
		int unsigned nic, noc, k, h, w;
		int unsigned idx;
		cur_dims(nic, noc, k, h, w);
		unique case (req.cmd)
			CMD_PIX: begin
				if (req.ic < nic && req.row < h && req.col < w) begin
					idx            = pix_addr(req.ic, req.row, req.col);
					pix_mem[idx]   = req.value;
					pix_known[idx] = 1'b1;
					useful_items++;
				end
			end
			CMD_WGT: begin
				if (req.oc < noc && req.ic < nic && req.kr < k && req.kc < k) begin
					idx            = wgt_addr(req.oc, req.ic, req.kr, req.kc);
					wgt_mem[idx]   = req.value;
					wgt_known[idx] = 1'b1;
					useful_items++;
				end
			end
			CMD_CALC: begin
				pending_sums.push_back(conv_window_sum(req));
				useful_items++;
			end
			default: ;
		endcase
	endfunction

	function automatic void note_mismatch(string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch at %0t ns: %s", $time, what);
		end
	endfunction

	function automatic logic [15:0] rand_q78();
		unique case ($urandom_range(0, 5))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return 16'($urandom_range(0, 511)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		conv_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sums.size() == 0) begin
				note_mismatch($sformatf("result with no request pending: sum %h status %0d",
					m_tdata, m_tuser));
			end else begin
				exp_res = pending_sums.pop_front();
				if (m_tdata !== exp_res.sum) begin
					note_mismatch($sformatf("sum expected %h got %h", exp_res.sum, m_tdata));
				end
				if (m_tuser !== exp_res.status) begin
					note_mismatch($sformatf("status expected %0d got %0d",
						exp_res.status, m_tuser));
				end
			end
		end
	end

	// result sink with random and long stalls
	always begin
		@(negedge clk);
		if (sink_hold) begin
			m_tready = 1'b0;
			repeat (SINK_HOLD) @(negedge clk);
			sink_hold = 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			m_tready = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		m_tready = 1'b1;
	end

	task automatic send_item(conv_req_t req);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = req.cmd;
		s_tdata  = {req.kc, req.kr, req.col, req.row, req.ic, req.oc, req.value};
		do @(posedge clk); while (!s_tready);
		apply_item(req);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_pixel(int unsigned ic, int unsigned r, int unsigned c,
			logic [15:0] v);
		conv_req_t req;
		req       = '0;
		req.cmd   = CMD_PIX;
		req.value = v;
		req.ic    = 2'(ic);
		req.row   = 6'(r);
		req.col   = 6'(c);
		send_item(req);
	endtask

	task automatic write_weight(int unsigned oc, int unsigned ic, int unsigned kr,
			int unsigned kc, logic [15:0] v);
		conv_req_t req;
		req       = '0;
		req.cmd   = CMD_WGT;
		req.value = v;
		req.oc    = 4'(oc);
		req.ic    = 2'(ic);
		req.kr    = 3'(kr);
		req.kc    = 3'(kc);
		send_item(req);
	endtask

	// for an in-window request, any tap not yet written gets a random value first
	task automatic compute_at(int unsigned oc, int unsigned r, int unsigned c);
		int unsigned nic, noc, k, h, w;
		conv_req_t   req;
		cur_dims(nic, noc, k, h, w);
		if (in_window(oc, r, c)) begin
			for (int i = 0; i < nic; i++) begin
				for (int a = 0; a < k; a++) begin
					for (int b = 0; b < k; b++) begin
						if (!pix_known[pix_addr(i, r + a, c + b)]) begin
							write_pixel(i, r + a, c + b, rand_q78());
						end
						if (!wgt_known[wgt_addr(oc, i, a, b)]) begin
							write_weight(oc, i, a, b, rand_q78());
						end
					end
				end
			end
		end
		req       = '0;
		req.cmd   = CMD_CALC;
		req.value = rand_q78();
		req.oc    = 4'(oc);
		req.row   = 6'(r);
		req.col   = 6'(c);
		send_item(req);
	endtask

	task automatic wait_idle();
		while (pending_sums.size() != 0) @(negedge clk);
		repeat (CALC_LATENCY + 10) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [6:0] val);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(posedge clk);
		unique case (idx)
			REG_IN_CH:  reg_in_ch  = val[2:0];
			REG_OUT_CH: reg_out_ch = val[4:0];
			REG_KSIZE:  reg_ksize  = val[2:0];
			REG_FH:     reg_fh     = val;
			REG_FW:     reg_fw     = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_shape(int unsigned nic, int unsigned noc, int unsigned k,
			int unsigned h, int unsigned w);
		wait_idle();
		write_reg(REG_IN_CH, 7'(nic));
		write_reg(REG_OUT_CH, 7'(noc));
		write_reg(REG_KSIZE, 7'(k));
		write_reg(REG_FH, 7'(h));
		write_reg(REG_FW, 7'(w));
	endtask

	task automatic random_shape();
		int unsigned v [5];
		v[0] = $urandom_range(1, 4);
		v[1] = $urandom_range(1, 16);
		v[2] = $urandom_range(1, 4);
		v[3] = $urandom_range(1, 12);
		v[4] = $urandom_range(1, 12);
		if ($urandom_range(0, 3) == 0) begin
			v[2] = $urandom_range(1, 7);
		end
		if ($urandom_range(0, 4) == 0) begin
			v[3] = $urandom_range(1, 64);
			v[4] = $urandom_range(1, 64);
		end
		// raw register value, may fall outside the usable range
		if ($urandom_range(0, 7) == 0) begin
			v[$urandom_range(0, 4)] = $urandom_range(0, 127);
		end
		set_shape(v[0], v[1], v[2], v[3], v[4]);
	endtask

	task automatic random_item();
		int unsigned nic, noc, k, h, w;
		int unsigned pick;
		conv_req_t   req;
		cur_dims(nic, noc, k, h, w);
		pick = $urandom_range(0, 19);
		if (pick < 12 && k <= h && k <= w) begin
			compute_at($urandom_range(0, noc - 1), $urandom_range(0, h - k),
				$urandom_range(0, w - k));
		end else if (pick < 14) begin
			compute_at($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 63));
		end else if (pick < 18) begin
			req       = conv_req_t'(REQ_W'({$urandom, $urandom}));
			req.cmd   = $urandom_range(0, 1) ? CMD_WGT : CMD_PIX;
			req.value = rand_q78();
			send_item(req);
		end else if (pick < 19) begin
			write_pixel($urandom_range(0, nic - 1), $urandom_range(0, h - 1),
				$urandom_range(0, w - 1), rand_q78());
		end else begin
			req     = conv_req_t'(REQ_W'({$urandom, $urandom}));
			req.cmd = CMD_NONE;
			send_item(req);
		end
	endtask

	task automatic test_reset_shape();
		conv_req_t req;
		compute_at(0, 0, 0);
		compute_at(0, 61, 61);
		compute_at(0, 62, 0);
		compute_at(0, 0, 62);
		compute_at(1, 0, 0);
		compute_at(15, 63, 63);
		// the next four writes fall outside the configured sizes
		write_pixel(1, 0, 0, Q_MAX);
		write_weight(0, 0, 3, 0, Q_MAX);
		write_weight(1, 0, 0, 0, Q_MAX);
		write_weight(0, 0, 7, 7, Q_MIN);
		req       = '0;
		req.cmd   = CMD_NONE;
		req.value = Q_MAX;
		req.oc    = 4'hF;
		send_item(req);
		write_pixel(0, 63, 63, Q_MIN);
		compute_at(0, 0, 0);
		compute_at(0, 61, 61);
	endtask

	task automatic test_saturation();
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				write_pixel(0, 20 + a, 20 + b, Q_MAX);
				write_weight(0, 0, a, b, Q_MAX);
			end
		end
		compute_at(0, 20, 20);
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				write_weight(0, 0, a, b, Q_MIN);
			end
		end
		compute_at(0, 20, 20);
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				write_pixel(0, 20 + a, 20 + b, Q_MIN);
			end
		end
		compute_at(0, 20, 20);
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				write_pixel(0, 20 + a, 20 + b, Q_ONE);
				write_weight(0, 0, a, b, Q_ONE);
			end
		end
		compute_at(0, 20, 20);
	endtask

	task automatic test_shape_extremes();
		set_shape(IN_CH_MAX, OUT_CH_MAX, KERN_MAX, ROWS_MAX, COLS_MAX);
		// full window of the most negative value drives the widest sum
		for (int i = 0; i < IN_CH_MAX; i++) begin
			for (int a = 0; a < KERN_MAX; a++) begin
				for (int b = 0; b < KERN_MAX; b++) begin
					write_pixel(i, 57 + a, 57 + b, Q_MIN);
					write_weight(15, i, a, b, Q_MIN);
				end
			end
		end
		compute_at(15, 57, 57);
		compute_at(15, 58, 57);
		compute_at(15, 57, 58);
		compute_at(15, 56, 57);
		set_shape(1, 1, 7, 6, 64);
		compute_at(0, 0, 0);
		set_shape(0, 0, 0, 0, 0);
		compute_at(0, 0, 0);
		compute_at(0, 0, 1);
		compute_at(1, 0, 0);
		set_shape(7, 31, 1, 127, 127);
		compute_at(15, 63, 63);
		compute_at(3, 0, 63);
	endtask

	task automatic test_backpressure();
		set_shape(1, 2, 3, 8, 8);
		sink_hold = 1'b1;
		repeat (12) begin
			compute_at($urandom_range(0, 1), $urandom_range(0, 5), $urandom_range(0, 5));
		end
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int stop_at;
		stop_at = useful_items + RANDOM_ITEMS;
		while (useful_items < stop_at) begin
			random_shape();
			repeat ($urandom_range(10, 30)) random_item();
		end
	endtask

	task automatic test_quiet_tail();
		random_shape();
		quiet = 1'b1;
		repeat (20) random_item();
	endtask

	initial begin
		int spins;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_reset_shape();
		test_saturation();
		test_shape_extremes();
		test_backpressure();
		test_random_traffic();
		test_quiet_tail();
		spins = 0;
		while (pending_sums.size() != 0 && spins < 100000) begin
			@(negedge clk);
			spins++;
		end
		repeat (CALC_LATENCY + 10) @(posedge clk);
		if (pending_sums.size() != 0) begin
			note_mismatch($sformatf("%0d results never arrived", pending_sums.size()));
		end
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/c2d_pkg.sv
src/c2d_ram.sv
src/conv2d_valid_multichannel_core.sv
dv/tb_top.sv
